FILE: sv/llps_pkg.sv
// Shared types, character codes and helpers for the log line priority sanitizer.
package llps_pkg;

  localparam int LINE_LIMIT_DEF  = 512;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [9:0]  DEFAULT_PRIO_RST = 10'd13;
  localparam logic [10:0] PRIO_MAX         = 11'd1023;
  localparam logic [10:0] ACC_SAT          = 11'd1024;
  localparam logic [6:0]  FAC_USER         = 7'd1;

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [3:0] DIGIT_CAP = 4'd7;
  localparam logic [6:0] CH_NL    = 7'h0A;
  localparam logic [6:0] CH_SP    = 7'h20;
  localparam logic [6:0] CH_CARET = 7'h5E;
  localparam logic [6:0] CH_DEL   = 7'h7F;
  localparam logic [6:0] CTRL_FLIP = 7'h40;

  // One queued request: zero, one or two characters plus the message priority.
  typedef struct packed {
    logic       has_char;
    logic       two;
    logic [6:0] c0;
    logic [6:0] c1;
    logic [9:0] prio;
    logic       last;
  } req_t;

  // Out-of-range value takes the default; kernel facility moves to user.
  function automatic logic [9:0] finalize_prio(input logic [10:0] v, input logic [9:0] dflt);
    logic [9:0] p;
    p = (v > PRIO_MAX) ? dflt : v[9:0];
    if (p[9:3] == 7'd0) p = {FAC_USER, p[2:0]};
    return p;
  endfunction

endpackage

FILE: sv/llps_msg_if.sv
// Input channel: one raw message byte per request.
interface llps_msg_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source(output valid, in_byte, in_last, input ready);
  modport sink(input valid, in_byte, in_last, output ready);
endinterface

FILE: sv/llps_res_if.sv
// Output channel: one sanitized character or end marker per request.
interface llps_res_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       is_char;
  logic [9:0] priority_res;
  logic       out_last;

  modport source(output valid, out_char, is_char, priority_res, out_last, input ready);
  modport sink(input valid, out_char, is_char, priority_res, out_last, output ready);
endinterface

FILE: sv/llps_front.sv
// Front end: prefix parser, body classifier and line limit counter.
module llps_front #(
  parameter int LINE_LIMIT = llps_pkg::LINE_LIMIT_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [9:0]      cfg_data,
  llps_msg_if.sink        msg,
  input  logic            full,
  output logic            push,
  output llps_pkg::req_t  push_ent
);

  localparam int CW = $clog2(LINE_LIMIT + 1);
  localparam logic [CW-1:0] LIMIT = CW'(LINE_LIMIT);

  localparam logic [1:0] PH_START  = 2'd0;
  localparam logic [1:0] PH_DIGITS = 2'd1;
  localparam logic [1:0] PH_BODY   = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  logic [9:0]    default_priority;
  logic [1:0]    phase, phase_next;
  logic [10:0]   accum, accum_next;
  logic [CW-1:0] chars, chars_next;

  logic          accept;
  logic [6:0]    ch;
  logic          do_body;
  logic [3:0]    digit;
  logic [13:0]   acc_mul;
  logic [CW:0]   chars_p2;
  llps_pkg::req_t ent;

  assign accept    = msg.valid && msg.ready;
  assign msg.ready = !full;
  assign ch        = msg.in_byte[6:0];
  assign chars_p2  = {1'b0, chars} + (CW+1)'(2);

  always_comb begin
    phase_next = phase;
    accum_next = accum;
    chars_next = chars;
    do_body    = 1'b0;
    digit      = msg.in_byte[3:0];
    if (digit > llps_pkg::DIGIT_CAP) digit = llps_pkg::DIGIT_CAP;
    acc_mul    = 14'(accum) * 14'd10 + 14'(digit);
    ent        = '0;

    case (phase)
      PH_START: begin
        if (msg.in_byte == llps_pkg::CH_LT) begin
          accum_next = '0;
          phase_next = PH_DIGITS;
        end else begin
          accum_next = 11'(llps_pkg::finalize_prio(11'(default_priority), default_priority));
          phase_next = PH_BODY;
          do_body    = 1'b1;
        end
      end
      PH_DIGITS: begin
        if (msg.in_byte >= llps_pkg::CH_ZERO && msg.in_byte <= llps_pkg::CH_NINE) begin
          accum_next = (acc_mul > 14'(llps_pkg::PRIO_MAX)) ? llps_pkg::ACC_SAT
                                                            : acc_mul[10:0];
        end else begin
          accum_next = 11'(llps_pkg::finalize_prio(accum, default_priority));
          phase_next = PH_BODY;
          do_body    = (msg.in_byte != llps_pkg::CH_GT);
        end
      end
      PH_BODY: do_body = 1'b1;
      default: ;
    endcase

    if (do_body) begin
      if (ch == 7'd0) begin
        phase_next = PH_DONE;
      end else if (chars < LIMIT) begin
        ent.has_char = 1'b1;
        if (ch == llps_pkg::CH_NL) begin
          ent.c0     = llps_pkg::CH_SP;
          chars_next = chars + CW'(1);
        end else if (ch < llps_pkg::CH_SP || ch == llps_pkg::CH_DEL) begin
          ent.two    = 1'b1;
          ent.c0     = llps_pkg::CH_CARET;
          ent.c1     = ch ^ llps_pkg::CTRL_FLIP;
          chars_next = (chars_p2 > {1'b0, LIMIT}) ? LIMIT : chars_p2[CW-1:0];
        end else begin
          ent.c0     = ch;
          chars_next = chars + CW'(1);
        end
      end
    end

    // a message that ends inside the prefix settles from the digits so far
    ent.prio = (phase_next == PH_DIGITS) ? llps_pkg::finalize_prio(accum_next, default_priority)
                                         : accum_next[9:0];
    ent.last = msg.in_last;
  end

  assign push     = accept && (ent.has_char || msg.in_last);
  assign push_ent = ent;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_priority <= llps_pkg::DEFAULT_PRIO_RST;
      phase            <= PH_START;
      accum            <= '0;
      chars            <= '0;
    end else begin
      if (cfg_we) default_priority <= cfg_data;
      if (accept) begin
        if (msg.in_last) begin
          phase <= PH_START;
          accum <= '0;
          chars <= '0;
        end else begin
          phase <= phase_next;
          accum <= accum_next;
          chars <= chars_next;
        end
      end
    end
  end

endmodule

FILE: sv/llps_queue.sv
// Short request queue between the parser and the output stage.
module llps_queue #(
  parameter int DEPTH = llps_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  llps_pkg::req_t push_ent,
  output logic           full,
  input  logic           pop,
  output llps_pkg::req_t head,
  output logic           empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  llps_pkg::req_t entries [DEPTH];
  logic [AW-1:0]  wr_ptr, rd_ptr;
  logic [NW-1:0]  count;
  logic           do_push, do_pop;

  assign full    = (count == NW'(DEPTH));
  assign empty   = (count == '0);
  assign head    = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_ent;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == LAST_IDX) ? '0 : wr_ptr + AW'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == LAST_IDX) ? '0 : rd_ptr + AW'(1);
      case ({do_push, do_pop})
        2'b10:   count <= count + NW'(1);
        2'b01:   count <= count - NW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: sv/llps_back.sv
// Back end: expands queued requests into single results behind an output register.
module llps_back (
  input  logic           clk,
  input  logic           rst,
  input  llps_pkg::req_t head,
  input  logic           empty,
  output logic           pop,
  llps_res_if.source     res
);

  logic       out_valid;
  logic [6:0] out_char;
  logic       is_char;
  logic [9:0] prio;
  logic       out_last;
  logic       sub;
  logic       load, first_of_two;

  assign load         = !out_valid || res.ready;
  assign first_of_two = head.two && !sub;
  assign pop          = load && !empty && !first_of_two;

  assign res.valid        = out_valid;
  assign res.out_char     = out_char;
  assign res.is_char      = is_char;
  assign res.priority_res = prio;
  assign res.out_last     = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sub       <= 1'b0;
    end else if (load) begin
      out_valid <= !empty;
      if (!empty) sub <= first_of_two;
    end
  end

  always_ff @(posedge clk) begin
    if (load && !empty) begin
      out_char <= sub ? head.c1 : head.c0;
      is_char  <= head.has_char;
      prio     <= head.prio;
      out_last <= head.last && !first_of_two;
    end
  end

endmodule

FILE: sv/log_line_priority_sanitizer_top.sv
// Path: an accepted byte's request is written into the queue, then loaded into the output register.
// Throughput: one byte per cycle unless the queue is full; a control character gives two results,
// absorbed in short bursts by the QUEUE_DEPTH request queue; a long run of them stalls the input.
// Reset (synchronous, rst high): default priority 13, parser at message start,
// character count zero, queue and output register empty.
module log_line_priority_sanitizer_top #(
  parameter int LINE_LIMIT  = llps_pkg::LINE_LIMIT_DEF,
  parameter int QUEUE_DEPTH = llps_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [9:0]  cfg_data,
  llps_msg_if.sink    msg,
  llps_res_if.source  res
);

  logic           push, full, pop, empty;
  llps_pkg::req_t push_ent, head;

  llps_front #(.LINE_LIMIT(LINE_LIMIT)) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .msg      (msg),
    .full     (full),
    .push     (push),
    .push_ent (push_ent)
  );

  llps_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_ent (push_ent),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  llps_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .empty (empty),
    .pop   (pop),
    .res   (res)
  );

endmodule

FILE: test/llps_line_checker.sv
// Checker for the log line sanitizer: tracks priority parsing and compares each result.
`timescale 1ns / 100ps

module llps_line_checker (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [9:0] cfg_data,
  llps_msg_if msg,
  llps_res_if res,
  output int fail_count,
  output int pending_count
);

  typedef enum logic [1:0] {
    PARSE_START,
    PARSE_DIGITS,
    PARSE_BODY,
    PARSE_DONE
  } parse_phase_t;

  typedef struct packed {
    logic [6:0] ch;
    logic       is_char;
    logic [9:0] prio;
    logic       last;
  } line_res_t;

  parse_phase_t phase;
  logic [10:0]  prio_acc;
  logic [9:0]   char_count;
  logic [9:0]   dflt_prio;

  line_res_t line_res_q[$];
  line_res_t step_res[2];
  int        step_n;
  line_res_t want;

  function automatic logic [9:0] settle_prio(input logic [10:0] v);
    logic [9:0] p;
    p = (v > llps_pkg::PRIO_MAX) ? dflt_prio : v[9:0];
    // kernel facility is moved to user, level kept
    if (p[9:3] == 7'd0) p = {llps_pkg::FAC_USER, p[2:0]};
    return p;
  endfunction

  task automatic clear_line();
    phase      = PARSE_START;
    prio_acc   = '0;
    char_count = '0;
  endtask

  task automatic emit(input logic [6:0] c);
    step_res[step_n] = '{ch: c, is_char: 1'b1, prio: prio_acc[9:0], last: 1'b0};
    step_n++;
    if (char_count < llps_pkg::LINE_LIMIT_DEF) char_count++;
  endtask

  task automatic take_body(input logic [7:0] b);
    logic [6:0] c;
    c = b[6:0];
    if (c == 7'd0) begin
      phase = PARSE_DONE;
    end else if (char_count < llps_pkg::LINE_LIMIT_DEF) begin
      if (c == llps_pkg::CH_NL) begin
        emit(llps_pkg::CH_SP);
      end else if (c < llps_pkg::CH_SP || c == llps_pkg::CH_DEL) begin
        emit(llps_pkg::CH_CARET);
        emit(c ^ llps_pkg::CTRL_FLIP);
      end else begin
        emit(c);
      end
    end
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic last);
    int digit;
    int acc;
    step_n = 0;
    case (phase)
      PARSE_START: begin
        if (b == llps_pkg::CH_LT) begin
          prio_acc = '0;
          phase    = PARSE_DIGITS;
        end else begin
          prio_acc = {1'b0, settle_prio({1'b0, dflt_prio})};
          phase    = PARSE_BODY;
          take_body(b);
        end
      end
      PARSE_DIGITS: begin
        if (b >= llps_pkg::CH_ZERO && b <= llps_pkg::CH_NINE) begin
          digit = int'(b - llps_pkg::CH_ZERO);
          if (digit > int'(llps_pkg::DIGIT_CAP)) digit = int'(llps_pkg::DIGIT_CAP);
          acc = 10 * int'(prio_acc) + digit;
          prio_acc = (acc > int'(llps_pkg::PRIO_MAX)) ? llps_pkg::ACC_SAT : 11'(acc);
        end else begin
          prio_acc = {1'b0, settle_prio(prio_acc)};
          phase    = PARSE_BODY;
          if (b != llps_pkg::CH_GT) take_body(b);
        end
      end
      PARSE_BODY: take_body(b);
      default: ;
    endcase

    if (last) begin
      // message may end while still inside the digits
      if (phase == PARSE_DIGITS) prio_acc = {1'b0, settle_prio(prio_acc)};
      if (step_n == 0) begin
        step_res[0] = '{ch: 7'd0, is_char: 1'b0, prio: prio_acc[9:0], last: 1'b0};
        step_n = 1;
      end
      step_res[step_n-1].last = 1'b1;
      clear_line();
    end

    for (int k = 0; k < step_n; k++) line_res_q.push_back(step_res[k]);
  endtask

  task automatic report(input string field, input int exp_val, input int got_val);
    if (fail_count < 50) $error("%s: expected %0d, actual %0d", field, exp_val, got_val);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      dflt_prio = llps_pkg::DEFAULT_PRIO_RST;
      clear_line();
      line_res_q.delete();
    end else begin
      if (res.valid && res.ready) begin
        if (line_res_q.size() == 0) begin
          if (fail_count < 50)
            $error("unexpected result: out_char %0d is_char %0d priority_res %0d out_last %0d",
                   res.out_char, res.is_char, res.priority_res, res.out_last);
          fail_count++;
        end else begin
          want = line_res_q.pop_front();
          if (res.out_char !== want.ch) report("out_char", want.ch, res.out_char);
          if (res.is_char !== want.is_char) report("is_char", want.is_char, res.is_char);
          if (res.priority_res !== want.prio)
            report("priority_res", want.prio, res.priority_res);
          if (res.out_last !== want.last) report("out_last", want.last, res.out_last);
        end
      end
      if (cfg_we) dflt_prio = cfg_data;
      if (msg.valid && msg.ready) predict_byte(msg.in_byte, msg.in_last);
    end
    pending_count = line_res_q.size();
  end

endmodule

FILE: test/tb_log_line_priority_sanitizer_top.sv
// Testbench top for the log line sanitizer: clock, reset, message stimulus and verdict.
`timescale 1ns / 100ps

module tb_log_line_priority_sanitizer_top;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  logic [9:0] cfg_data;

  llps_msg_if msg_ch ();
  llps_res_if res_ch ();

  int chk_fails;
  int chk_pending;

  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  int hold_left     = 0;
  int sent_items    = 0;

  logic [7:0] msg_bytes[$];

  log_line_priority_sanitizer_top dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .msg      (msg_ch),
    .res      (res_ch)
  );

  llps_line_checker chk (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .msg           (msg_ch),
    .res           (res_ch),
    .fail_count    (chk_fails),
    .pending_count (chk_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("FAILURE");
    $finish;
  end

  // Result side: random backpressure, plus long hold-offs on request.
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so the next request can follow back to back.
  task automatic push_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      msg_ch.valid <= 1'b0;
      @(negedge clk);
    end
    msg_ch.valid   <= 1'b1;
    msg_ch.in_byte <= b;
    msg_ch.in_last <= last;
    do @(posedge clk); while (!msg_ch.ready);
    @(negedge clk);
    sent_items++;
  endtask

  task automatic send_message();
    foreach (msg_bytes[i]) push_byte(msg_bytes[i], i == msg_bytes.size() - 1);
  endtask

  task automatic drain();
    msg_ch.valid <= 1'b0;
    while (chk_pending != 0) @(negedge clk);
    // bytes that give no result may still be in flight
    repeat (4) @(negedge clk);
  endtask

  task automatic write_default(input logic [9:0] v);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  function automatic logic [7:0] pick_body_byte();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 8'($urandom_range(8'h20, 8'h7E));
    if (r < 70) return {1'b0, llps_pkg::CH_NL};
    if (r < 82) return 8'($urandom_range(8'h01, 8'h1F));
    if (r < 85) return {1'b0, llps_pkg::CH_DEL};
    if (r < 97) return 8'($urandom_range(8'h80, 8'hFF));
    return {1'($urandom_range(1)), 7'd0};
  endfunction

  task automatic send_random_message();
    int nd;
    int nb;
    msg_bytes.delete();
    if ($urandom_range(99) < 75) begin
      // well formed prefix, sometimes empty or unterminated
      msg_bytes.push_back(llps_pkg::CH_LT);
      nd = $urandom_range(4);
      repeat (nd) msg_bytes.push_back(8'(llps_pkg::CH_ZERO + $urandom_range(9)));
      if ($urandom_range(9) != 0) msg_bytes.push_back(llps_pkg::CH_GT);
      nb = $urandom_range(16);
    end else begin
      nb = $urandom_range(1, 12);
      msg_bytes.push_back(8'($urandom_range(255)));
      nb--;
    end
    repeat (nb) msg_bytes.push_back(pick_body_byte());
    send_message();
  endtask

  task automatic run_phase(input int src_pct, input int sink_pct, input logic [9:0] dflt,
                           input int n_items);
    int stop_at;
    write_default(dflt);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    stop_at = sent_items + n_items;
    while (sent_items < stop_at) send_random_message();
  endtask

  initial begin
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_data       = '0;
    msg_ch.valid   = 1'b0;
    msg_ch.in_byte = '0;
    msg_ch.in_last = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_default(10'd0);
    msg_bytes = '{8'h41};
    send_message();
    msg_bytes = '{llps_pkg::CH_LT, 8'h39, 8'h38, llps_pkg::CH_GT, 8'h7F, 8'h0A};
    send_message();
    msg_bytes = '{llps_pkg::CH_LT, 8'h37, 8'h37, 8'h37, 8'h37, 8'hC1};
    send_message();
    write_default(10'd1023);
    msg_bytes = '{llps_pkg::CH_LT, 8'h32};
    send_message();
    msg_bytes = '{llps_pkg::CH_LT, 8'h1B};
    send_message();
    msg_bytes = '{8'h78, 8'h80, 8'h79};
    send_message();
    msg_bytes = '{8'h5A, llps_pkg::CH_LT};
    send_message();
    msg_bytes = '{8'h00};
    send_message();
    msg_bytes = '{8'hFF};
    send_message();
    // default is taken at the first byte; a later write must not change it
    push_byte(8'h71, 1'b0);
    write_default(10'd200);
    push_byte(8'h72, 1'b1);

    run_phase(6, 83, 10'($urandom_range(1023)), 200);
    run_phase(83, 6, 10'd0, 200);
    run_phase(0, 0, 10'd1023, 100);

    msg_ch.valid <= 1'b0;
    @(posedge clk);
    hold_left = 300;
    @(negedge clk);
    repeat (40) send_random_message();
    drain();

    // line limit: a two-character expansion starting at the last free slot
    msg_bytes = '{llps_pkg::CH_LT, 8'h33, llps_pkg::CH_GT};
    repeat (511) msg_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
    msg_bytes.push_back(8'h01);
    repeat (5) msg_bytes.push_back(pick_body_byte());
    send_message();

    run_phase(0, 0, 10'd5, 100);

    drain();
    repeat (10) @(negedge clk);
    if (chk_fails == 0 && chk_pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
